// ===== design/grid_diffusion_stencil_step_defines.svh =====
// assertion macros shared by the block
`ifndef GRID_DIFFUSION_STENCIL_STEP_DEFINES_SVH
`define GRID_DIFFUSION_STENCIL_STEP_DEFINES_SVH

// implication in the same cycle
`define GDS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gds assertion failed");

// implication in the next cycle
`define GDS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gds assertion failed");

`endif

// ===== design/gds_pkg.sv =====
`timescale 1ns / 1ps
package gds_pkg;
    localparam int MAX_COLUMNS = 1024;
    localparam int ADDR_W      = $clog2(MAX_COLUMNS);
    localparam int GCOL_W      = 11;
    localparam int ROW_W       = 16;
    localparam int RATE_W      = 16;
    localparam int CNT_W       = ((ADDR_W > GCOL_W) ? ADDR_W : GCOL_W) + 1;
    localparam int FED_W       = GCOL_W + ROW_W;
    localparam int HEIGHT_W    = 32;
    localparam int CELL_W      = HEIGHT_W + 1;
    localparam int DIAG_WEIGHT = 46341;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int MIN_COLUMNS = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_RATE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MOORE = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_COLS  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = CFG_IDX_W'(3);

    localparam logic [GCOL_W-1:0] RST_COLS = GCOL_W'(1024);
    localparam logic [ROW_W-1:0]  RST_ROWS = ROW_W'(1024);

    typedef logic [CELL_W-1:0] t_cell;

    typedef struct packed {
        logic              start;
        logic              take;
        logic              moore;
        logic [2:0]        ok_row;
        logic [2:0]        ok_col;
        logic [RATE_W-1:0] rate;
        t_cell [8:0]       win;
    } t_upd_req;

    typedef struct packed {
        logic                done;
        logic [HEIGHT_W-1:0] height;
        logic                absent;
    } t_upd_rsp;
endpackage

// ===== design/gds_if.sv =====
`timescale 1ns / 1ps
interface gds_in_if;
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic signed [gds_pkg::HEIGHT_W-1:0] height;
    logic                          absent;
    modport source (output valid, kind, height, absent, input ready);
    modport sink (input valid, kind, height, absent, output ready);
endinterface

interface gds_out_if;
    logic                          valid;
    logic                          ready;
    logic signed [gds_pkg::HEIGHT_W-1:0] new_height;
    logic                          out_absent;
    logic                          frame_end;
    modport source (output valid, new_height, out_absent, frame_end, input ready);
    modport sink (input valid, new_height, out_absent, frame_end, output ready);
endinterface

interface gds_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [gds_pkg::CFG_IDX_W-1:0]     index;
    logic [gds_pkg::CFG_DATA_W-1:0]    data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== design/gds_line_store.sv =====
`timescale 1ns / 1ps
module gds_line_store import gds_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rd,
    input  logic              i_wr,
    input  logic [ADDR_W-1:0] i_addr,
    input  t_cell             i_wr_upper,
    input  t_cell             i_wr_middle,
    output t_cell             o_upper,
    output t_cell             o_middle
);
    t_cell r_upper  [MAX_COLUMNS];
    t_cell r_middle [MAX_COLUMNS];
    t_cell r_up_q;
    t_cell r_mid_q;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_upper[i_addr]  <= i_wr_upper;
            r_middle[i_addr] <= i_wr_middle;
        end
        if (i_rd) begin
            r_up_q  <= r_upper[i_addr];
            r_mid_q <= r_middle[i_addr];
        end
    end

    assign o_upper  = r_up_q;
    assign o_middle = r_mid_q;
endmodule

// ===== design/gds_update.sv =====
`timescale 1ns / 1ps
`include "grid_diffusion_stencil_step_defines.svh"
module gds_update import gds_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_upd_req i_req,
    output t_upd_rsp o_rsp
);
    localparam int SUM_W = HEIGHT_W + 3;
    localparam int S_W   = SUM_W + 18;
    localparam int P_W   = S_W + RATE_W + 1;
    localparam int D_W   = P_W - 32;

    logic [2:0]                 r_stg;
    logic signed [SUM_W-1:0]    r_so;
    logic signed [SUM_W-1:0]    r_sd;
    logic signed [HEIGHT_W-1:0] r_z;
    logic                       r_abs;
    logic [RATE_W-1:0]          r_rate;
    logic signed [S_W-1:0]      r_s;
    logic signed [D_W-1:0]      r_delta;
    logic signed [SUM_W-1:0]    n_so;
    logic signed [SUM_W-1:0]    n_sd;
    logic signed [HEIGHT_W:0]   w_diff [9];
    logic signed [S_W-1:0]      w_dprod;
    logic signed [P_W-1:0]      w_round;
    logic signed [D_W:0]        w_sum;
    logic [HEIGHT_W-1:0]        w_sat;

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            w_diff[k] = $signed({i_req.win[k][HEIGHT_W-1], i_req.win[k][HEIGHT_W-1:0]})
                      - $signed({i_req.win[4][HEIGHT_W-1], i_req.win[4][HEIGHT_W-1:0]});
        end
    end

    always_comb begin
        n_so = '0;
        n_sd = '0;
        for (int k = 0; k < 9; k++) begin
            if (k != 4 && i_req.ok_row[k / 3] && i_req.ok_col[k % 3]
                    && !i_req.win[k][HEIGHT_W]) begin
                if (k / 3 != 1 && k % 3 != 1) begin
                    if (i_req.moore) begin
                        n_sd = n_sd + SUM_W'(w_diff[k]);
                    end
                end else begin
                    n_so = n_so + SUM_W'(w_diff[k]);
                end
            end
        end
    end

    assign w_dprod = S_W'(r_sd) * $signed(S_W'(DIAG_WEIGHT));
    assign w_round = (P_W'(r_s) * $signed({{(P_W-RATE_W){1'b0}}, r_rate}))
                   + (P_W'(1) <<< 31);
    assign w_sum   = (D_W+1)'(r_delta) + (D_W+1)'(r_z);

    always_comb begin
        if (w_sum[D_W:HEIGHT_W-1] == '0 || w_sum[D_W:HEIGHT_W-1] == '1) begin
            w_sat = w_sum[HEIGHT_W-1:0];
        end else if (w_sum[D_W]) begin
            w_sat = {1'b1, {(HEIGHT_W-1){1'b0}}};
        end else begin
            w_sat = {1'b0, {(HEIGHT_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg <= '0;
        end else begin
            r_stg[0] <= i_req.start;
            r_stg[1] <= r_stg[0];
            if (r_stg[1]) begin
                r_stg[2] <= 1'b1;
            end else if (i_req.take) begin
                r_stg[2] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_so   <= n_so;
            r_sd   <= n_sd;
            r_z    <= $signed(i_req.win[4][HEIGHT_W-1:0]);
            r_abs  <= i_req.win[4][HEIGHT_W];
            r_rate <= i_req.rate;
        end
        if (r_stg[0]) begin
            r_s <= (S_W'(r_so) <<< 16) + w_dprod;
        end
        if (r_stg[1]) begin
            r_delta <= w_round[P_W-1:32];
        end
    end

    assign o_rsp.done   = r_stg[2];
    assign o_rsp.height = r_abs ? r_z : w_sat;
    assign o_rsp.absent = r_abs;

    `GDS_ASSERT_IMPL(a_one_stage, i_clk, i_rst_n, 1'b1, $onehot0(r_stg))
    `GDS_ASSERT_NEXT(a_take_clears, i_clk, i_rst_n, i_req.take && r_stg[2], !r_stg[2])
    `GDS_ASSERT_NEXT(a_start_stage, i_clk, i_rst_n, i_req.start, r_stg[0])
endmodule

// ===== design/grid_diffusion_stencil_step.sv =====
`timescale 1ns / 1ps
`include "grid_diffusion_stencil_step_defines.svh"
// one diffusion pass over a raster-ordered grid: cells come in one at a time, two line
// stores of up to 1024 columns and a 3x3 window hold the old heights, and each result
// leaves grid_columns+1 items after its cell, so drain items flush the tail of the grid.
// an ignored drain item ends after the check, other items without a result after the
// window shift, and one with a result when its update is done and the output is free;
// store reads are registered; weighting and rate multiply take three registered steps.
// the line store read and write of one item fall in different cycles and items do not
// overlap, so no forwarding is needed. a result may wait in the output register while the
// next item is taken in. there is no clearing pass after reset.
module grid_diffusion_stencil_step import gds_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gds_in_if.sink    i_in,
    gds_out_if.source o_out,
    gds_cfg_if.sink   i_cfg
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_WIN   = 3'd2;
    localparam logic [2:0] S_ARITH = 3'd3;

    logic [2:0]          r_state;
    logic                r_kind;
    logic [HEIGHT_W-1:0] r_height;
    logic                r_absent;
    logic [RATE_W-1:0]   r_rate;
    logic                r_moore;
    logic [GCOL_W-1:0]   r_gcols;
    logic [ROW_W-1:0]    r_grows;
    logic [FED_W-1:0]    r_total;
    logic [FED_W-1:0]    r_fed;
    logic [ADDR_W-1:0]   r_col;
    logic [FED_W-1:0]    r_emit;
    logic [ADDR_W-1:0]   r_ocol;
    logic [ROW_W-1:0]    r_orow;
    t_cell [8:0]         r_win;
    logic                r_start;
    logic [2:0]          r_okr;
    logic [2:0]          r_okc;
    logic                r_fend;
    logic                r_ov;
    logic [HEIGHT_W-1:0] r_oh;
    logic                r_oa;
    logic                r_of;

    logic [CNT_W-1:0]  w_w;
    logic [ROW_W-1:0]  w_h;
    logic              w_restart;
    logic              w_ignore;
    logic              w_free;
    logic              w_take;
    logic [ADDR_W-1:0] w_addr;
    t_cell             w_up;
    t_cell             w_mid;
    t_cell             w_inc;
    t_upd_req          w_req;
    t_upd_rsp          w_rsp;

    always_comb begin
        if (r_gcols < GCOL_W'(MIN_COLUMNS)) begin
            w_w = CNT_W'(MIN_COLUMNS);
        end else if (CNT_W'(r_gcols) > CNT_W'(MAX_COLUMNS)) begin
            w_w = CNT_W'(MAX_COLUMNS);
        end else begin
            w_w = CNT_W'(r_gcols);
        end
    end

    assign w_h       = (r_grows == '0) ? ROW_W'(1) : r_grows;
    assign w_restart = !r_kind && (r_fed >= r_total);
    assign w_ignore  = r_kind && ((r_fed < r_total) || (r_emit >= r_total));
    assign w_addr    = (r_state == S_CHECK && w_restart) ? '0 : r_col;
    assign w_inc     = r_kind ? {1'b1, {HEIGHT_W{1'b0}}} : {r_absent, r_height};
    assign w_free    = !r_ov || o_out.ready;
    assign w_take    = (r_state == S_ARITH) && w_rsp.done && w_free;

    gds_line_store u_store (
        .i_clk       (i_clk),
        .i_rd        (r_state == S_CHECK && !w_ignore),
        .i_wr        (r_state == S_WIN && !r_kind),
        .i_addr      (w_addr),
        .i_wr_upper  (w_mid),
        .i_wr_middle (w_inc),
        .o_upper     (w_up),
        .o_middle    (w_mid)
    );

    assign w_req.start  = r_start;
    assign w_req.take   = w_take;
    assign w_req.moore  = r_moore;
    assign w_req.ok_row = r_okr;
    assign w_req.ok_col = r_okc;
    assign w_req.rate   = r_rate;
    assign w_req.win    = r_win;

    gds_update u_update (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rate  <= '0;
            r_moore <= 1'b1;
            r_gcols <= RST_COLS;
            r_grows <= RST_ROWS;
            r_total <= FED_W'(RST_COLS) * FED_W'(RST_ROWS);
            r_fed   <= '0;
            r_col   <= '0;
            r_emit  <= '0;
            r_ocol  <= '0;
            r_orow  <= '0;
            r_win   <= '0;
            r_start <= 1'b0;
        end else begin
            r_total <= FED_W'(w_w) * FED_W'(w_h);
            r_start <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (w_ignore) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_WIN;
                        if (w_restart) begin
                            r_fed  <= '0;
                            r_col  <= '0;
                            r_emit <= '0;
                            r_ocol <= '0;
                            r_orow <= '0;
                        end
                    end
                end
                S_WIN: begin
                    r_win[0] <= r_win[1];
                    r_win[1] <= r_win[2];
                    r_win[2] <= w_up;
                    r_win[3] <= r_win[4];
                    r_win[4] <= r_win[5];
                    r_win[5] <= w_mid;
                    r_win[6] <= r_win[7];
                    r_win[7] <= r_win[8];
                    r_win[8] <= w_inc;
                    r_fed    <= r_fed + FED_W'(1);
                    if (CNT_W'(r_col) + CNT_W'(1) >= w_w) begin
                        r_col <= '0;
                    end else begin
                        r_col <= r_col + ADDR_W'(1);
                    end
                    if (r_fed < FED_W'(w_w) + FED_W'(1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_ARITH;
                        r_start <= 1'b1;
                        r_emit  <= r_emit + FED_W'(1);
                        if (CNT_W'(r_ocol) + CNT_W'(1) >= w_w) begin
                            r_ocol <= '0;
                            r_orow <= r_orow + ROW_W'(1);
                        end else begin
                            r_ocol <= r_ocol + ADDR_W'(1);
                        end
                    end
                end
                S_ARITH: begin
                    if (w_take) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    CFG_RATE: begin
                        r_rate <= i_cfg.data[RATE_W-1:0];
                    end
                    CFG_MOORE: begin
                        r_moore <= i_cfg.data[0];
                    end
                    CFG_COLS: begin
                        r_gcols <= i_cfg.data[GCOL_W-1:0];
                        r_fed   <= '0;
                        r_col   <= '0;
                        r_emit  <= '0;
                        r_ocol  <= '0;
                        r_orow  <= '0;
                    end
                    CFG_ROWS: begin
                        r_grows <= i_cfg.data[ROW_W-1:0];
                        r_fed   <= '0;
                        r_col   <= '0;
                        r_emit  <= '0;
                        r_ocol  <= '0;
                        r_orow  <= '0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // item capture and per-result position flags
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in.valid) begin
            r_kind   <= i_in.kind;
            r_height <= i_in.height;
            r_absent <= i_in.absent;
        end
        if (r_state == S_WIN) begin
            r_okr  <= {(ROW_W+1)'(r_orow) + (ROW_W+1)'(1) < (ROW_W+1)'(w_h), 1'b1,
                       r_orow != '0};
            r_okc  <= {CNT_W'(r_ocol) + CNT_W'(1) < w_w, 1'b1, r_ocol != '0};
            r_fend <= (r_emit == r_total - FED_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_take) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_oh <= w_rsp.height;
            r_oa <= w_rsp.absent;
            r_of <= r_fend;
        end
    end

    assign i_in.ready       = (r_state == S_IDLE);
    assign i_cfg.ready      = 1'b1;
    assign o_out.valid      = r_ov;
    assign o_out.new_height = r_oh;
    assign o_out.out_absent = r_oa;
    assign o_out.frame_end  = r_of;

    `GDS_ASSERT_IMPL(a_col_range, i_clk, i_rst_n, 1'b1, CNT_W'(r_col) < w_w)
    `GDS_ASSERT_IMPL(a_emit_bound, i_clk, i_rst_n, 1'b1, r_emit <= r_total)
    `GDS_ASSERT_IMPL(a_start_arith, i_clk, i_rst_n, r_start, r_state == S_ARITH)
endmodule
